// File: hw/rtl/fra_pkg.sv
// Shared types and constants for the fraction arithmetic and reduction block.
package fra_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int OPCODE_W          = 2;
  localparam int STATUS_W          = 2;
  localparam int NUM_W             = 33;
  localparam int DEN_W             = 31;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNDEF   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

endpackage

// File: hw/rtl/fraction_arith_reduce.sv
// Top level: exact add/sub/mul/div of two signed fractions, reduced by their gcd.
//
// One item at a time. An accepted transfer is checked for zero operands first; a
// rejected item goes straight to the result register. Otherwise three magnitude
// products come out of one registered multiplier, a combine step forms the
// numerator (a second, reversed subtract when |q| > |p|), a binary gcd runs on the
// shared adder/subtractor (one shift or subtract-and-halve per cycle, plus a swap
// step when the smaller value is on top; a swap is always followed by a subtract),
// then the same adder performs two restoring divisions by the gcd, one quotient bit
// per cycle. The gcd loop makes the work per item vary with its operands. A zero
// sum skips the gcd and both divisions. in_stall is high while an item is in work.
// A finished result sits in the output register until its transfer, and a new
// item may already be taken meanwhile.
module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fra_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic signed [OPERAND_WIDTH-1:0]    in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]    in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]    in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]    in_b_den,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fra_pkg::STATUS_W-1:0]       out_status,
  output logic signed [fra_pkg::NUM_W-1:0]   out_res_num,
  output logic [fra_pkg::DEN_W-1:0]          out_res_den
);
  import fra_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int MW    = 2 * W;        // product magnitude
  localparam int PW    = MW + 1;       // numerator magnitude after add
  localparam int UW    = PW + 1;       // shared adder width
  localparam int CNT_W = $clog2(PW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MULW,
    S_COMB,
    S_COMB2,
    S_GCD_PAIR,
    S_GCD_ODD,
    S_DIV_N,
    S_DIV_D,
    S_FIN
  } state_t;

  state_t           state_r;
  opcode_t          op_r;
  status_t          status_r;
  logic [W-1:0]     an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic             s_an_r, s_ad_r, s_bn_r, s_bd_r;
  logic [MW-1:0]    pm_r, qm_r, dm_r;
  logic [PW-1:0]    u_r, v_r, n_r, d_r, g_r, rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [NUM_W-1:0]    out_num_r;
  logic [DEN_W-1:0]    out_den_r;

  // Input magnitudes and zero checks, taken on the accept edge.
  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic         an_z, ad_z, bn_z, bd_z;
  logic         chk_undef, chk_invalid;

  assign an_mag = in_a_num[W-1] ? $unsigned(-in_a_num) : $unsigned(in_a_num);
  assign ad_mag = in_a_den[W-1] ? $unsigned(-in_a_den) : $unsigned(in_a_den);
  assign bn_mag = in_b_num[W-1] ? $unsigned(-in_b_num) : $unsigned(in_b_num);
  assign bd_mag = in_b_den[W-1] ? $unsigned(-in_b_den) : $unsigned(in_b_den);
  assign an_z   = (in_a_num == '0);
  assign ad_z   = (in_a_den == '0);
  assign bn_z   = (in_b_num == '0);
  assign bd_z   = (in_b_den == '0);

  // Undefined: divide with a zero first denominator, or both numerators zero.
  assign chk_undef   = ((in_opcode == OP_DIV) && ad_z) || (an_z && bn_z);
  assign chk_invalid = an_z || ad_z || bn_z || bd_z;

  // Signs of the three products.
  logic p_neg, q_neg, d_neg, addsub_op;

  assign p_neg     = s_an_r ^ ((op_r == OP_MUL) ? s_bn_r : s_bd_r);
  assign q_neg     = s_ad_r ^ s_bn_r ^ (op_r == OP_SUB);
  assign d_neg     = s_ad_r ^ ((op_r == OP_DIV) ? s_bn_r : s_bd_r);
  assign addsub_op = (op_r == OP_ADD) || (op_r == OP_SUB);

  // Multiplier operand select: one product issued per cycle, its result registered in fra_mul.
  logic [W-1:0]  mul_a, mul_b;
  logic [MW-1:0] mul_p;

  always_comb begin
    mul_a = an_m_r;
    mul_b = bd_m_r;
    case (state_r)
      S_MUL1: begin
        mul_a = an_m_r;
        mul_b = (op_r == OP_MUL) ? bn_m_r : bd_m_r;
      end
      S_MUL2: begin
        mul_a = ad_m_r;
        mul_b = bn_m_r;
      end
      S_MUL3: begin
        mul_a = ad_m_r;
        mul_b = (op_r == OP_DIV) ? bn_m_r : bd_m_r;
      end
      default: begin
        mul_a = an_m_r;
        mul_b = bd_m_r;
      end
    endcase
  end

  fra_mul #(
    .WIDTH (W)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_p)
  );

  // Shared adder operand select.
  logic [UW-1:0] au_a, au_b, au_res;
  logic          au_sub, au_carry;

  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b1;
    case (state_r)
      S_COMB: begin
        au_a   = UW'(pm_r);
        au_b   = UW'(qm_r);
        au_sub = (p_neg != q_neg);
      end
      S_COMB2: begin
        au_a = UW'(qm_r);
        au_b = UW'(pm_r);
      end
      S_GCD_ODD: begin
        au_a = UW'(u_r);
        au_b = UW'(v_r);
      end
      S_DIV_N: begin
        au_a = {rem_r, n_r[PW-1]};
        au_b = UW'(g_r);
      end
      S_DIV_D: begin
        au_a = {rem_r, d_r[PW-1]};
        au_b = UW'(g_r);
      end
      default: begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b1;
      end
    endcase
  end

  fra_addsub #(
    .WIDTH (UW)
  ) u_addsub (
    .a     (au_a),
    .b     (au_b),
    .sub   (au_sub),
    .res   (au_res),
    .carry (au_carry)
  );

  // Result formatting: keep the low bits, apply the sign to the numerator.
  logic [PW+NUM_W-1:0] n_ext;
  logic [PW+DEN_W-1:0] d_ext;
  logic [NUM_W-1:0]    num_mag;

  assign n_ext   = {{NUM_W{1'b0}}, n_r};
  assign d_ext   = {{DEN_W{1'b0}}, d_r};
  assign num_mag = n_ext[NUM_W-1:0];

  logic in_xfer, out_free;

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once its transfer completes
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= opcode_t'(in_opcode);
            an_m_r <= an_mag;
            ad_m_r <= ad_mag;
            bn_m_r <= bn_mag;
            bd_m_r <= bd_mag;
            s_an_r <= in_a_num[W-1];
            s_ad_r <= in_a_den[W-1];
            s_bn_r <= in_b_num[W-1];
            s_bd_r <= in_b_den[W-1];
            if (chk_undef || chk_invalid) begin
              status_r <= chk_undef ? ST_UNDEF : ST_INVALID;
              n_r      <= '0;
              d_r      <= '0;
              neg_r    <= 1'b0;
              state_r  <= S_FIN;
            end else begin
              status_r <= ST_OK;
              state_r  <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          pm_r    <= mul_p;
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          qm_r    <= mul_p;
          state_r <= S_MULW;
        end
        S_MULW: begin
          dm_r    <= mul_p;
          state_r <= S_COMB;
        end
        S_COMB: begin
          v_r <= PW'(dm_r);
          if (!addsub_op) begin
            u_r     <= PW'(pm_r);
            neg_r   <= p_neg ^ d_neg;
            state_r <= S_GCD_PAIR;
          end else if ((p_neg == q_neg) || au_carry) begin
            // same signs add; opposite signs with |p| >= |q| subtract
            u_r     <= au_res[PW-1:0];
            neg_r   <= p_neg ^ d_neg;
            state_r <= S_GCD_PAIR;
          end else begin
            neg_r   <= q_neg ^ d_neg;
            state_r <= S_COMB2;
          end
        end
        S_COMB2: begin
          u_r     <= au_res[PW-1:0];
          state_r <= S_GCD_PAIR;
        end
        S_GCD_PAIR: begin
          if (u_r == '0) begin
            // zero result reads 0/1
            n_r     <= '0;
            d_r     <= PW'(1);
            neg_r   <= 1'b0;
            state_r <= S_FIN;
          end else if (!u_r[0] && !v_r[0]) begin
            // strip common factors of two; they are part of the gcd
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
          end else begin
            n_r     <= u_r;
            d_r     <= v_r;
            state_r <= S_GCD_ODD;
          end
        end
        S_GCD_ODD: begin
          if (u_r == '0 || v_r == '0) begin
            g_r     <= u_r | v_r;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV_N;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (au_carry) begin
            // both odd: difference is even, halve it in the same step
            u_r <= au_res[PW:1];
          end else begin
            u_r <= v_r;
            v_r <= u_r;
          end
        end
        S_DIV_N: begin
          rem_r <= au_carry ? au_res[PW-1:0] : au_a[PW-1:0];
          n_r   <= {n_r[PW-2:0], au_carry};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(PW - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          rem_r <= au_carry ? au_res[PW-1:0] : au_a[PW-1:0];
          d_r   <= {d_r[PW-2:0], au_carry};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(PW - 1)) begin
            cnt_r   <= '0;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_num_r    <= neg_r ? (~num_mag + 1'b1) : num_mag;
            out_den_r    <= d_ext[DEN_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_res_num = $signed(out_num_r);
  assign out_res_den = out_den_r;

  // A rejected item carries all-zero result fields.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_num_r == '0 && out_den_r == '0))
    else $error("error status with nonzero result fields");

  // The odd-gcd loop always keeps at least one odd operand.
  a_gcd_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD_ODD) |-> (u_r[0] || v_r[0]))
    else $error("gcd loop lost its odd operand");

  // Restoring division keeps the partial remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV_N) || (state_r == S_DIV_D)) |-> (rem_r < g_r))
    else $error("partial remainder not below gcd");

  // An accepted item closes the input until its result is formed.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input reopened right after a transfer");

endmodule

// File: hw/rtl/fra_mul.sv
// Unsigned magnitude multiplier with a registered product.
module fra_mul #(
  parameter int WIDTH = fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic               clk,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [2*WIDTH-1:0] prod_r
);
  import fra_pkg::*;

  logic [2*WIDTH-1:0] prod_nxt;

  assign prod_nxt = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: hw/rtl/fra_addsub.sv
// Shared adder/subtractor with carry out, used by the combine, gcd and divide steps.
module fra_addsub #(
  parameter int WIDTH = 2 * fra_pkg::OPERAND_WIDTH_DEF + 2
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] res,
  output logic             carry
);
  import fra_pkg::*;

  logic [WIDTH:0] sum;
  logic [WIDTH-1:0] b_eff;

  // carry set on a subtract means no borrow, i.e. a >= b
  assign b_eff = sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
  assign res   = sum[WIDTH-1:0];
  assign carry = sum[WIDTH];

endmodule

// File: sim/fraction_arith_reduce_chk.sv
// Checker for the fraction unit: predicts each reduced fraction and compares it on output.
`timescale 1ns / 100ps

module fraction_arith_reduce_chk #(
  parameter int W = fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [fra_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic signed [W-1:0]                in_a_num,
  input  logic signed [W-1:0]                in_a_den,
  input  logic signed [W-1:0]                in_b_num,
  input  logic signed [W-1:0]                in_b_den,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [fra_pkg::STATUS_W-1:0]       out_status,
  input  logic signed [fra_pkg::NUM_W-1:0]   out_res_num,
  input  logic [fra_pkg::DEN_W-1:0]          out_res_den,
  output int                                 fail_count,
  output int                                 pending
);
  import fra_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [NUM_W-1:0]  num;
    logic [DEN_W-1:0]         den;
  } fraction_t;

  fraction_t expected_fractions[$];
  int        mismatch_cnt = 0;

  // Exact rational result, reduced by the gcd, sign carried on the numerator.
  function automatic fraction_t reduce_fraction(opcode_t op, logic signed [W-1:0] an,
                                                logic signed [W-1:0] ad,
                                                logic signed [W-1:0] bn,
                                                logic signed [W-1:0] bd);
    fraction_t        r;
    longint           nsum, dprod;
    longint unsigned  nmag, dmag, g, x, t;
    logic             neg;
    r.status = ST_OK;
    r.num    = '0;
    r.den    = '0;
    if ((op == OP_DIV && ad == 0) || (an == 0 && bn == 0)) begin
      r.status = ST_UNDEF;
      return r;
    end
    if (an == 0 || ad == 0 || bn == 0 || bd == 0) begin
      r.status = ST_INVALID;
      return r;
    end
    case (op)
      OP_ADD: begin
        nsum  = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
        dprod = longint'(ad) * longint'(bd);
      end
      OP_SUB: begin
        nsum  = longint'(an) * longint'(bd) - longint'(ad) * longint'(bn);
        dprod = longint'(ad) * longint'(bd);
      end
      OP_MUL: begin
        nsum  = longint'(an) * longint'(bn);
        dprod = longint'(ad) * longint'(bd);
      end
      default: begin
        nsum  = longint'(an) * longint'(bd);
        dprod = longint'(ad) * longint'(bn);
      end
    endcase
    nmag = (nsum < 0) ? longint'(-nsum) : nsum;
    dmag = (dprod < 0) ? longint'(-dprod) : dprod;
    g = nmag;
    x = dmag;
    while (x != 0) begin
      t = g % x;
      g = x;
      x = t;
    end
    if (g == 0)
      g = 1;
    nmag = nmag / g;
    dmag = dmag / g;
    if (nmag == 0) begin
      r.den = 1;
      return r;
    end
    neg   = (nsum < 0) != (dprod < 0);
    r.num = neg ? NUM_W'(-nmag) : NUM_W'(nmag);
    r.den = dmag[DEN_W-1:0];
    return r;
  endfunction

  task automatic note_failure(string what, fraction_t want, fraction_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s: expected status %0d num %0d den %0d, got status %0d num %0d den %0d",
               $realtime, what, want.status, want.num, want.den,
               got.status, got.num, got.den);
  endtask

  always @(posedge clk) begin : watch
    fraction_t got, want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_fractions.push_back(reduce_fraction(opcode_t'(in_opcode), in_a_num,
                                                     in_a_den, in_b_num, in_b_den));
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.num    = out_res_num;
        got.den    = out_res_den;
        if (expected_fractions.size() == 0) begin
          want = '0;
          note_failure("unexpected result", want, got);
        end else begin
          want = expected_fractions.pop_front();
          if (got.status !== want.status || got.num !== want.num || got.den !== want.den)
            note_failure("result mismatch", want, got);
        end
      end
    end
    pending    <= expected_fractions.size();
    fail_count <= mismatch_cnt;
  end

endmodule

// File: sim/fraction_arith_reduce_tb.sv
// Testbench top for the fraction unit: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module fraction_arith_reduce_tb;
  import fra_pkg::*;

  localparam int W = OPERAND_WIDTH_DEF;

  // Random part size and the tail of the run that goes without any idling.
  localparam int RANDOM_ITEMS = 430;
  localparam int CALM_ITEMS   = 60;
  // Long receiver hold-off: well beyond two items of work, so the block
  // fills its output register, takes one more item and then stalls its input.
  localparam int HOLD_AFTER   = 120;
  localparam int HOLD_CYCLES  = 600;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OPCODE_W-1:0]      in_opcode = '0;
  logic signed [W-1:0]      in_a_num = '0;
  logic signed [W-1:0]      in_a_den = '0;
  logic signed [W-1:0]      in_b_num = '0;
  logic signed [W-1:0]      in_b_den = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [NUM_W-1:0]  out_res_num;
  logic [DEN_W-1:0]         out_res_den;

  int fail_count;
  int pending;
  int rx_count = 0;
  bit calm = 1'b0;

  always #6 clk = ~clk;

  fraction_arith_reduce #(.OPERAND_WIDTH(W)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den)
  );

  fraction_arith_reduce_chk #(.W(W)) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Offer one fraction pair and hold it until the block takes the transfer.
  // An optional idle burst goes first; valid stays high between back-to-back
  // items so that it only gets one assignment per edge.
  task automatic offer_fractions(opcode_t op, logic signed [W-1:0] an,
                                 logic signed [W-1:0] ad, logic signed [W-1:0] bn,
                                 logic signed [W-1:0] bd);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_a_num  <= an;
    in_a_den  <= ad;
    in_b_num  <= bn;
    in_b_den  <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mix full-range values with small ones (frequent common factors and zero
  // results) and the corner values of the 16-bit range.
  function automatic logic signed [W-1:0] pick_operand();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          3: v = 1;
          default: v = 0;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 24)) - 12;
      default: v = $urandom;
    endcase
    return v[W-1:0];
  endfunction

  // Count completed result transfers; the receiver uses it to place its long hold.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      rx_count <= rx_count + 1;
  end

  // Receiver: random stall bursts, one long hold-off, and no stalls once calm.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!held && rx_count >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    opcode_t             op;
    logic signed [W-1:0] an, ad, bn, bd;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain cases of every operation, negative denominators included.
    offer_fractions(OP_ADD, 1, 2, 1, 3);
    offer_fractions(OP_SUB, 1, 2, 3, 4);
    offer_fractions(OP_MUL, -2, 3, 9, 4);
    offer_fractions(OP_DIV, 3, -4, -9, 8);
    // Undefined: divide with a zero first denominator, or both numerators zero.
    offer_fractions(OP_DIV, 5, 0, 3, 7);
    offer_fractions(OP_DIV, 0, 0, 0, 7);
    offer_fractions(OP_ADD, 0, 5, 0, 7);
    offer_fractions(OP_MUL, 0, 3, 0, 0);
    // Invalid: any other zero numerator or denominator.
    offer_fractions(OP_ADD, 0, 5, 3, 7);
    offer_fractions(OP_SUB, 5, 0, 3, 7);
    offer_fractions(OP_MUL, 5, 3, 0, 7);
    offer_fractions(OP_DIV, 5, 3, 7, 0);
    offer_fractions(OP_DIV, 5, 3, 0, 7);
    // Zero results normalize to 0/1; a self-division reduces to 1/1.
    offer_fractions(OP_SUB, 3, 4, 3, 4);
    offer_fractions(OP_ADD, 1, 2, 1, -2);
    offer_fractions(OP_DIV, 7, 9, 7, 9);
    // Range corners: largest numerator and denominator magnitudes.
    offer_fractions(OP_ADD, -32768, 32767, -32768, 32767);
    offer_fractions(OP_ADD, -32768, -32768, -32768, -32768);
    offer_fractions(OP_SUB, 32767, -32768, -32768, 32767);
    offer_fractions(OP_MUL, -32768, 1, -32768, 1);
    offer_fractions(OP_MUL, 32767, -32768, 32765, 32767);
    offer_fractions(OP_DIV, -32768, 32767, 1, -32768);
    offer_fractions(OP_DIV, 1, -32768, -32768, 1);
    offer_fractions(OP_ADD, -1, -1, 32767, 32767);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS)
        calm = 1'b1;
      op = opcode_t'($urandom_range(0, 3));
      an = pick_operand();
      ad = pick_operand();
      // Now and then repeat the first fraction to hit zero and unit results.
      if ($urandom_range(0, 7) == 0) begin
        bn = an;
        bd = ad;
      end else begin
        bn = pick_operand();
        bd = pick_operand();
      end
      offer_fractions(op, an, ad, bn, bd);
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then keep watching for any stray result.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
